@@ rtl/core/crp_pkg.sv @@
// Shared types and constants for the complex roots to polynomial core.
// No dependencies; used by crp_ctrl, crp_dp and the top level.
`timescale 1ns / 1ps

package crp_pkg;

	// Default highest polynomial order
	localparam int MAX_ORDER_DEF = 8;

	// Field widths
	localparam int ROOT_W = 18;
	localparam int COEF_W = 32;
	localparam int CIDX_W = 4;
	localparam int CFG_W  = 32;
	localparam int CFGA_W = 2;

	// Stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	// Q16.16 unity
	localparam logic signed [COEF_W-1:0] ONE_Q16 = 32'sd65536;

	// Configuration register indexes
	localparam logic [CFGA_W-1:0] CFG_GAIN_RE    = 2'd0;
	localparam logic [CFGA_W-1:0] CFG_GAIN_IM    = 2'd1;
	localparam logic [CFGA_W-1:0] CFG_APPLY_GAIN = 2'd2;

	// Datapath operation on one coefficient
	typedef enum logic [1:0] {
		OP_UPD,
		OP_GAIN,
		OP_EMIT
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic issue;
		op_t  op;
		logic last;
		logic load_root;
		logic set_ovf;
		logic clear_run;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic busy;
		logic out_free;
		logic apply_gain;
	} stat_t;

endpackage

@@ rtl/core/complex_roots_to_polynomial_core.sv @@
// Complex roots to polynomial: top level joining crp_ctrl and crp_dp (uses crp_pkg).
// A root taken when k roots are held occupies the core while its k + 1 coefficients issue
// through the shared complex multiplier, then while its read, product and rounding stages drain.
// On the last root, an enabled gain pass runs first; output reads one coefficient at a time,
// once the pipe and output register are free; the last beat may wait while the next root is taken.
// Reset (arst_n, async): registers to defaults, store reads as 1, 0, 0 ... via valid bits.
`timescale 1ns / 1ps

module complex_roots_to_polynomial_core #(
	parameter int MAX_ORDER = crp_pkg::MAX_ORDER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Root beats
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [crp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // root_re, root_im, pad
	input  logic                                 s_axis_tlast,  // last_root
	// Coefficient beats
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [crp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // coef_re, coef_im, coef_index, pad
	output logic                                 m_axis_tlast,  // last_coef
	output logic                                 m_axis_tuser,  // overflow
	// Configuration
	input  logic                                 cfg_we,
	input  logic [crp_pkg::CFGA_W-1:0]           cfg_addr,
	input  logic [crp_pkg::CFG_W-1:0]            cfg_wdata
);

	localparam int NCOEF = MAX_ORDER + 1;
	localparam int IDX_W = $clog2(NCOEF);
	localparam int RW    = crp_pkg::ROOT_W;
	localparam int CW    = crp_pkg::COEF_W;
	localparam int PADW  = crp_pkg::OUT_TDATA_W - 2 * CW - crp_pkg::CIDX_W;

	crp_pkg::cmd_t      cmd;
	crp_pkg::stat_t     stat;
	logic [IDX_W-1:0]   issue_addr;

	logic signed [CW-1:0]         coef_re;
	logic signed [CW-1:0]         coef_im;
	logic [crp_pkg::CIDX_W-1:0]   coef_index;

	crp_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_last    (s_axis_tlast),
		.s_ready   (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd),
		.issue_addr(issue_addr)
	);

	crp_dp #(
		.MAX_ORDER(MAX_ORDER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.issue_addr(issue_addr),
		.root_re   (s_axis_tdata[RW-1:0]),
		.root_im   (s_axis_tdata[2*RW-1:RW]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.coef_re   (coef_re),
		.coef_im   (coef_im),
		.coef_index(coef_index),
		.last_coef (m_axis_tlast),
		.overflow  (m_axis_tuser)
	);

	// Pack the coefficient beat
	assign m_axis_tdata = {{PADW{1'b0}}, coef_index, coef_im, coef_re};

`ifndef NO_ASSERTIONS
	// A root is only taken with the pipe empty
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !stat.busy)
		else $error("root accepted while pipe busy");

	// An emit read never overlaps work in flight
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && (cmd.op == crp_pkg::OP_EMIT)) |-> !stat.busy)
		else $error("emit issued with pipe busy");

	// The store is cleared only after the pipe drains
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_run |-> (!stat.busy && !cmd.issue))
		else $error("store cleared with work in flight");

	// The last coefficient of a run is followed by a ready input side
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_run |=> s_axis_tready)
		else $error("core not ready after run end");
`endif

endmodule

@@ rtl/core/crp_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 9,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/core/crp_ctrl.sv @@
// Sequencer for root updates, gain pass and coefficient output.
// Depends on crp_pkg; drives crp_dp through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module crp_ctrl #(
	parameter int MAX_ORDER = crp_pkg::MAX_ORDER_DEF,
	localparam int NCOEF = MAX_ORDER + 1,
	localparam int IDX_W = $clog2(NCOEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	input  logic               s_last,
	output logic               s_ready,
	input  crp_pkg::stat_t     stat,
	output crp_pkg::cmd_t      cmd,
	output logic [IDX_W-1:0]   issue_addr
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_UPD_WAIT,
		ST_GAIN,
		ST_GAIN_WAIT,
		ST_EMIT,
		ST_EMIT_WAIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;

	logic accept;
	logic full;
	logic emit_ok;
	logic emit_last;

	assign s_ready    = (state_q == ST_IDLE);
	assign accept     = s_valid && s_ready;
	assign full       = (count_q == IDX_W'(MAX_ORDER));
	assign emit_ok    = !stat.busy && stat.out_free;
	assign emit_last  = (idx_q == count_q);
	assign issue_addr = idx_q;

	// Decode commands from state
	always_comb begin
		cmd    = '0;
		cmd.op = crp_pkg::OP_UPD;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_root = accept;
				cmd.set_ovf   = accept && full;
			end
			ST_UPD: begin
				cmd.issue = 1'b1;
				cmd.op    = crp_pkg::OP_UPD;
			end
			ST_GAIN: begin
				cmd.issue = 1'b1;
				cmd.op    = crp_pkg::OP_GAIN;
			end
			ST_EMIT: begin
				cmd.issue = emit_ok;
				cmd.op    = crp_pkg::OP_EMIT;
				cmd.last  = emit_last;
			end
			ST_EMIT_WAIT: begin
				cmd.clear_run = !stat.busy;
			end
			default: begin
			end
		endcase
	end

	// Hold state, root count and coefficient index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_last;
						if (!full) begin
							idx_q   <= count_q;
							state_q <= ST_UPD;
						end else if (s_last) begin
							idx_q   <= '0;
							state_q <= stat.apply_gain ? ST_GAIN : ST_EMIT;
						end
					end
				end
				ST_UPD: begin
					if (idx_q == '0) begin
						count_q <= count_q + IDX_W'(1);
						state_q <= ST_UPD_WAIT;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_UPD_WAIT: begin
					if (!stat.busy) begin
						idx_q <= '0;
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= stat.apply_gain ? ST_GAIN : ST_EMIT;
						end
					end
				end
				ST_GAIN: begin
					if (idx_q == count_q) begin
						state_q <= ST_GAIN_WAIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_GAIN_WAIT: begin
					if (!stat.busy) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						if (emit_last) begin
							state_q <= ST_EMIT_WAIT;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_EMIT_WAIT: begin
					if (!stat.busy) begin
						count_q <= '0;
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/crp_dp.sv @@
// Coefficient datapath: store, shared complex multiplier, rounding and output register.
// Depends on crp_pkg and crp_ram; commanded by crp_ctrl.
`timescale 1ns / 1ps

module crp_dp #(
	parameter int MAX_ORDER = crp_pkg::MAX_ORDER_DEF,
	localparam int NCOEF = MAX_ORDER + 1,
	localparam int IDX_W = $clog2(NCOEF)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  crp_pkg::cmd_t                         cmd,
	input  logic [IDX_W-1:0]                      issue_addr,
	input  logic signed [crp_pkg::ROOT_W-1:0]     root_re,
	input  logic signed [crp_pkg::ROOT_W-1:0]     root_im,
	input  logic                                  cfg_we,
	input  logic [crp_pkg::CFGA_W-1:0]            cfg_addr,
	input  logic [crp_pkg::CFG_W-1:0]             cfg_wdata,
	output crp_pkg::stat_t                        stat,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [crp_pkg::COEF_W-1:0]     coef_re,
	output logic signed [crp_pkg::COEF_W-1:0]     coef_im,
	output logic [crp_pkg::CIDX_W-1:0]            coef_index,
	output logic                                  last_coef,
	output logic                                  overflow
);

	localparam int CW   = crp_pkg::COEF_W;
	localparam int PW   = 2 * CW;
	localparam int SW   = PW + 1;
	localparam int RW   = SW - 16;
	localparam int DW   = RW + 1;
	localparam int EXTW = CW - crp_pkg::ROOT_W;

	// Configuration and root registers
	logic signed [CW-1:0]               gain_re_q;
	logic signed [CW-1:0]               gain_im_q;
	logic                               apply_q;
	logic signed [crp_pkg::ROOT_W-1:0]  root_re_q;
	logic signed [crp_pkg::ROOT_W-1:0]  root_im_q;

	// Store state
	logic [NCOEF-1:0] valid_q;
	logic             ovf_q;

	// RAM ports
	logic [IDX_W-1:0] raddr_b;
	logic [2*CW-1:0]  rdata_a;
	logic [2*CW-1:0]  rdata_b;
	logic [2*CW-1:0]  wdata;
	logic             we;

	// Stage 1: read data
	logic               v_s1;
	crp_pkg::op_t       op_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   waddr_s1;
	logic               last_s1;
	logic               va_s1;
	logic               vb_s1;

	// Stage 2: products
	logic               v_s2;
	crp_pkg::op_t       op_s2;
	logic [IDX_W-1:0]   waddr_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [CW-1:0] tgt_re_s2, tgt_im_s2;

	// Stage 3: rounded sums
	logic               v_s3;
	crp_pkg::op_t       op_s3;
	logic [IDX_W-1:0]   waddr_s3;
	logic signed [RW-1:0] rnd_re_s3, rnd_im_s3;
	logic signed [CW-1:0] tgt_re_s3, tgt_im_s3;

	// Output register
	logic out_vld_q;

	// Combinational
	logic signed [CW-1:0] a_re, a_im, b_re, b_im, t_re, t_im;
	logic signed [SW-1:0] sum_re, sum_im;
	logic signed [DW-1:0] wb_re, wb_im;
	logic                 sat_re, sat_im;
	logic signed [CW-1:0] res_re, res_im;
	logic [IDX_W+crp_pkg::CIDX_W-1:0] idx_wide;

	crp_ram #(
		.WIDTH(2 * CW),
		.DEPTH(NCOEF)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr_s3),
		.wdata  (wdata),
		.raddr_a(issue_addr),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// Target of an update is the next entry up
	assign raddr_b = (cmd.op == crp_pkg::OP_UPD) ? issue_addr + IDX_W'(1) : issue_addr;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_re_q <= crp_pkg::ONE_Q16;
			gain_im_q <= '0;
			apply_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crp_pkg::CFG_GAIN_RE:    gain_re_q <= cfg_wdata;
				crp_pkg::CFG_GAIN_IM:    gain_im_q <= cfg_wdata;
				crp_pkg::CFG_APPLY_GAIN: apply_q   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Latch the accepted root
	always_ff @(posedge clk) begin
		if (cmd.load_root) begin
			root_re_q <= root_re;
			root_im_q <= root_im;
		end
	end

	// Stage valids, entry valid bits and the sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && (op_s1 != crp_pkg::OP_EMIT);
			v_s3 <= v_s2;
			if (cmd.clear_run) begin
				valid_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (we) begin
					valid_q[waddr_s3] <= 1'b1;
				end
				if (cmd.set_ovf || (we && (sat_re || sat_im))) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Stage 1 side information travels with the read
	always_ff @(posedge clk) begin
		op_s1    <= cmd.op;
		idx_s1   <= issue_addr;
		waddr_s1 <= raddr_b;
		last_s1  <= cmd.last;
		va_s1    <= valid_q[issue_addr];
		vb_s1    <= valid_q[raddr_b];
	end

	// Unwritten entries read as the reset polynomial
	always_comb begin
		if (va_s1) begin
			a_re = rdata_a[CW-1:0];
			a_im = rdata_a[2*CW-1:CW];
		end else begin
			a_re = (idx_s1 == '0) ? crp_pkg::ONE_Q16 : '0;
			a_im = '0;
		end
		if (vb_s1) begin
			t_re = rdata_b[CW-1:0];
			t_im = rdata_b[2*CW-1:CW];
		end else begin
			t_re = (waddr_s1 == '0) ? crp_pkg::ONE_Q16 : '0;
			t_im = '0;
		end
		if (op_s1 == crp_pkg::OP_UPD) begin
			b_re = {{EXTW{root_re_q[crp_pkg::ROOT_W-1]}}, root_re_q};
			b_im = {{EXTW{root_im_q[crp_pkg::ROOT_W-1]}}, root_im_q};
		end else begin
			b_re = gain_re_q;
			b_im = gain_im_q;
		end
	end

	// Stage 2: four products of the shared complex multiplier
	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		waddr_s2  <= (op_s1 == crp_pkg::OP_UPD) ? waddr_s1 : idx_s1;
		p0_s2     <= a_re * b_re;
		p1_s2     <= a_im * b_im;
		p2_s2     <= a_im * b_re;
		p3_s2     <= a_re * b_im;
		tgt_re_s2 <= t_re;
		tgt_im_s2 <= t_im;
	end

	// Stage 3: combine and round to nearest, ties up
	assign sum_re = {p0_s2[PW-1], p0_s2} - {p1_s2[PW-1], p1_s2} + SW'(32768);
	assign sum_im = {p2_s2[PW-1], p2_s2} + {p3_s2[PW-1], p3_s2} + SW'(32768);

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		waddr_s3  <= waddr_s2;
		rnd_re_s3 <= sum_re[SW-1:16];
		rnd_im_s3 <= sum_im[SW-1:16];
		tgt_re_s3 <= tgt_re_s2;
		tgt_im_s3 <= tgt_im_s2;
	end

	// Writeback: subtract from target for updates, then saturate
	always_comb begin
		if (op_s3 == crp_pkg::OP_UPD) begin
			wb_re = {{(DW-CW){tgt_re_s3[CW-1]}}, tgt_re_s3} - {rnd_re_s3[RW-1], rnd_re_s3};
			wb_im = {{(DW-CW){tgt_im_s3[CW-1]}}, tgt_im_s3} - {rnd_im_s3[RW-1], rnd_im_s3};
		end else begin
			wb_re = {rnd_re_s3[RW-1], rnd_re_s3};
			wb_im = {rnd_im_s3[RW-1], rnd_im_s3};
		end
		sat_re = (wb_re[DW-1:CW-1] != {(DW-CW+1){wb_re[DW-1]}});
		sat_im = (wb_im[DW-1:CW-1] != {(DW-CW+1){wb_im[DW-1]}});
		if (sat_re) begin
			res_re = wb_re[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			res_re = wb_re[CW-1:0];
		end
		if (sat_im) begin
			res_im = wb_im[DW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			res_im = wb_im[CW-1:0];
		end
	end

	assign we    = v_s3;
	assign wdata = {res_im, res_re};

	// Output register: loaded by an emit read, dropped when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (v_s1 && (op_s1 == crp_pkg::OP_EMIT)) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign idx_wide = {{crp_pkg::CIDX_W{1'b0}}, idx_s1};

	always_ff @(posedge clk) begin
		if (v_s1 && (op_s1 == crp_pkg::OP_EMIT)) begin
			coef_re    <= a_re;
			coef_im    <= a_im;
			coef_index <= idx_wide[crp_pkg::CIDX_W-1:0];
			last_coef  <= last_s1;
			overflow   <= ovf_q;
		end
	end

	assign out_valid       = out_vld_q;
	assign stat.busy       = v_s1 || v_s2 || v_s3;
	assign stat.out_free   = !out_vld_q || out_ready;
	assign stat.apply_gain = apply_q;

endmodule
